// File: hw/rtl/rpa_pkg.sv
// Package with shared constants, types and helpers for the rotor position averager.
`timescale 1ns / 1ps

package rpa_pkg;

  localparam int WindowSize = 16;
  localparam int SampleW    = 10;
  localparam int IdxW       = $clog2(WindowSize);
  localparam int SumW       = SampleW + $clog2(WindowSize);
  localparam int PosW       = 16;
  localparam int DirW       = 8;

  // Reciprocal of three in 11 fractional bits; exact for every 10-bit value.
  localparam int Div3Mult  = 683;
  localparam int Div3Shift = 11;

  typedef enum logic [1:0] {
    CmdSample = 2'd0,
    CmdStart  = 2'd1,
    CmdStop   = 2'd2,
    CmdStatus = 2'd3
  } cmd_e;

  localparam logic [DirW-1:0] DirPlus  = 8'd1;
  localparam logic [DirW-1:0] DirMinus = 8'd2;

  typedef struct packed {
    logic            start;
    logic            stop;
    logic [DirW-1:0] dir;
  } relay_ctrl_t;

  typedef struct packed {
    logic plus;
    logic minus;
  } relay_lvl_t;

  function automatic logic [SampleW-1:0] div3(input logic [SampleW-1:0] x);
    logic [2*SampleW-1:0] prod;
    prod = (2*SampleW)'(x) * (2*SampleW)'(Div3Mult);
    return SampleW'(prod >> Div3Shift);
  endfunction

endpackage

// File: hw/rtl/rpa_window.sv
// Sample ring, write index and running sum of the last feedback readings.
`timescale 1ns / 1ps

module rpa_window
  import rpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               sample_we_i,
  input  logic [SampleW-1:0] sample_i,
  output logic [SumW-1:0]    sum_next_o
);

  logic [SampleW-1:0] ring_q [WindowSize];
  logic [IdxW-1:0]    idx_q, idx_d;
  logic [SumW-1:0]    sum_q, sum_d;

  always_comb begin
    sum_d = sum_q - SumW'(ring_q[idx_q]) + SumW'(sample_i);
    if (idx_q == IdxW'(WindowSize - 1)) begin
      idx_d = '0;
    end else begin
      idx_d = idx_q + IdxW'(1);
    end
  end

  assign sum_next_o = sample_we_i ? sum_d : sum_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < WindowSize; i++) begin
        ring_q[i] <= '0;
      end
      idx_q <= '0;
      sum_q <= '0;
    end else if (sample_we_i) begin
      ring_q[idx_q] <= sample_i;
      idx_q         <= idx_d;
      sum_q         <= sum_d;
    end
  end

endmodule

// File: hw/rtl/rpa_relay.sv
// Relay pin levels, both active low, set by start and stop words.
`timescale 1ns / 1ps

module rpa_relay
  import rpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  relay_ctrl_t ctrl_i,
  output relay_lvl_t  lvl_next_o
);

  relay_lvl_t lvl_q, lvl_d;

  always_comb begin
    lvl_d = lvl_q;
    priority if (ctrl_i.start && ctrl_i.dir == DirPlus) begin
      lvl_d = '{plus: 1'b0, minus: 1'b1};
    end else if (ctrl_i.start && ctrl_i.dir == DirMinus) begin
      lvl_d = '{plus: 1'b1, minus: 1'b0};
    end else if (ctrl_i.start || ctrl_i.stop) begin
      lvl_d = '{plus: 1'b1, minus: 1'b1};
    end else begin
      lvl_d = lvl_q;
    end
  end

  assign lvl_next_o = lvl_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q <= '{plus: 1'b1, minus: 1'b1};
    end else begin
      lvl_q <= lvl_d;
    end
  end

endmodule

// File: hw/rtl/rotor_position_averager_relay_top.sv
// Top level: handshake, calibration register, position arithmetic and result register.
`timescale 1ns / 1ps

// Every accepted word gives one result word in the next cycle, and a new word
// is taken every cycle while the result register is free or being drained.
// The rate is set by the running-sum update of the sample ring. The position
// is the window average divided by three plus the calibration offset, modulo
// 65536; pin levels are low when a relay is active.
module rotor_position_averager_relay_top
  import rpa_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_wr_en_i,
  input  logic [PosW-1:0]    cfg_wr_data_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         command_i,
  input  logic [SampleW-1:0] adc_sample_i,
  input  logic [DirW-1:0]    direction_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [PosW-1:0]    position_o,
  output logic               plus_pin_o,
  output logic               minus_pin_o
);

  logic            accept;
  cmd_e            cmd;
  logic [PosW-1:0] offset_q;
  logic            valid_q;
  logic [PosW-1:0] pos_q, pos_d;
  relay_lvl_t      lvl_q;
  relay_lvl_t      lvl_next;
  relay_ctrl_t     relay_ctrl;
  logic [SumW-1:0] sum_next;
  logic [SampleW-1:0] avg;

  assign in_ready_o = !valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;
  assign cmd        = cmd_e'(command_i);

  assign relay_ctrl.start = accept && (cmd == CmdStart);
  assign relay_ctrl.stop  = accept && (cmd == CmdStop);
  assign relay_ctrl.dir   = direction_i;

  rpa_window u_window (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .sample_we_i (accept && (cmd == CmdSample)),
    .sample_i    (adc_sample_i),
    .sum_next_o  (sum_next)
  );

  rpa_relay u_relay (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctrl_i     (relay_ctrl),
    .lvl_next_o (lvl_next)
  );

  assign avg   = SampleW'(sum_next / WindowSize);
  assign pos_d = PosW'(div3(avg)) + offset_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q <= '0;
      valid_q  <= 1'b0;
    end else begin
      if (cfg_wr_en_i) begin
        offset_q <= cfg_wr_data_i;
      end
      if (accept) begin
        valid_q <= 1'b1;
      end else if (out_ready_i) begin
        valid_q <= 1'b0;
      end
    end
  end

  // The result word is held until it is taken.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= pos_d;
      lvl_q <= lvl_next;
    end
  end

  assign out_valid_o = valid_q;
  assign position_o  = pos_q;
  assign plus_pin_o  = lvl_q.plus;
  assign minus_pin_o = lvl_q.minus;

endmodule
